FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the debounce block.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TBDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tbdc_pkg.sv
// Shared types and constants for the two-button debouncer.
// No dependencies.
package tbdc_pkg;

  localparam int unsigned TimeBits = 32;
  localparam int unsigned CfgBits  = 16;
  localparam int unsigned IdxBits  = 2;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [CfgBits-1:0]  cfg_val_t;

  // Register map of the configuration port.
  typedef enum logic [IdxBits-1:0] {
    CfgDebounce  = 2'd0,
    CfgLongPress = 2'd1,
    CfgComboHold = 2'd2
  } cfg_idx_e;

  localparam cfg_val_t DebounceRst  = 16'd50;
  localparam cfg_val_t LongPressRst = 16'd3000;
  localparam cfg_val_t ComboHoldRst = 16'd3000;

  typedef struct packed {
    cfg_val_t debounce;
    cfg_val_t long_press;
    cfg_val_t combo_hold;
  } cfg_t;

  // One poll as seen by a processing unit; en marks the cycle it is consumed.
  typedef struct packed {
    logic  en;
    logic  raw;
    time_t now;
  } btn_step_t;

  typedef struct packed {
    logic  en;
    logic  both_low;
    time_t now;
  } combo_step_t;

  // Widen a configuration value to timestamp width.
  function automatic time_t cfg_to_time(input cfg_val_t v);
    return time_t'(v);
  endfunction

endpackage

FILE: rtl/tbdc_cfg_regs.sv
// Configuration register file of the debouncer.
// Depends on tbdc_pkg.
module tbdc_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  tbdc_pkg::cfg_val_t      cfg_data_i,
  output tbdc_pkg::cfg_t          cfg_o
);
  import tbdc_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce   <= DebounceRst;
      cfg_q.long_press <= LongPressRst;
      cfg_q.combo_hold <= ComboHoldRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDebounce:  cfg_q.debounce   <= cfg_data_i;
        CfgLongPress: cfg_q.long_press <= cfg_data_i;
        CfgComboHold: cfg_q.combo_hold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/tbdc_button.sv
// Debounce and short/long press tracking for one button.
// Depends on tbdc_pkg.
module tbdc_button (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbdc_pkg::btn_step_t step_i,
  input  tbdc_pkg::cfg_t      cfg_i,
  output logic                short_o,
  output logic                stable_o
);
  import tbdc_pkg::*;

  logic  prev_q, stable_q, long_q;
  time_t last_q, press_q;

  logic  prev_d, stable_d, long_d;
  time_t last_d, press_d;

  logic  changed, settled, flip, press, release_ev, long_base, long_ok;
  time_t el_db;

  always_comb begin
    changed    = step_i.raw != prev_q;
    last_d     = changed ? step_i.now : last_q;
    el_db      = changed ? '0 : (step_i.now - last_q);
    settled    = el_db > cfg_to_time(cfg_i.debounce);
    flip       = settled && (step_i.raw != stable_q);
    press      = flip && !step_i.raw;
    release_ev = flip && step_i.raw;
    stable_d   = flip ? step_i.raw : stable_q;
    press_d    = press ? step_i.now : press_q;
    long_base  = press ? 1'b0 : long_q;
    // A fresh press has zero elapsed time, so only a zero threshold counts.
    long_ok    = press ? (cfg_i.long_press == '0)
                       : ((step_i.now - press_q) >= cfg_to_time(cfg_i.long_press));
    long_d     = long_base | (!stable_d && long_ok);
    prev_d     = step_i.raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b1;
      stable_q <= 1'b1;
      long_q   <= 1'b0;
      last_q   <= '0;
      press_q  <= '0;
    end else if (step_i.en) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      long_q   <= long_d;
      last_q   <= last_d;
      press_q  <= press_d;
    end
  end

  assign short_o  = step_i.en && release_ev && !long_q;
  assign stable_o = step_i.en ? stable_d : stable_q;

endmodule

FILE: rtl/tbdc_combo.sv
// Two-button combo hold detector.
// Depends on tbdc_pkg.
module tbdc_combo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbdc_pkg::combo_step_t step_i,
  input  tbdc_pkg::cfg_t        cfg_i,
  output logic                  event_o
);
  import tbdc_pkg::*;

  logic  active_q, handled_q;
  time_t start_q;

  logic  active_d, handled_d, handled_base, hold_ok, fire;
  time_t start_d;

  always_comb begin
    handled_base = active_q ? handled_q : 1'b0;
    hold_ok      = active_q ? ((step_i.now - start_q) >= cfg_to_time(cfg_i.combo_hold))
                            : (cfg_i.combo_hold == '0);
    fire         = step_i.both_low && !handled_base && hold_ok;
    if (step_i.both_low) begin
      active_d  = 1'b1;
      start_d   = active_q ? start_q : step_i.now;
      handled_d = handled_base | fire;
    end else begin
      active_d  = 1'b0;
      start_d   = '0;
      handled_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      handled_q <= 1'b0;
      start_q   <= '0;
    end else if (step_i.en) begin
      active_q  <= active_d;
      handled_q <= handled_d;
      start_q   <= start_d;
    end
  end

  assign event_o = step_i.en && fire;

endmodule

FILE: rtl/two_button_debounce_long_press_combo.sv
// Two-button debouncer with short-press detection and a both-buttons combo.
//
// Input channel: one beat per poll carries btn1_level_i, btn2_level_i (active
// low, 0 means pressed) and now_ms_i, a millisecond timestamp that wraps
// modulo 2^32. A beat is taken at a rising edge with in_valid_i high and
// in_stall_o low. Output channel: every poll produces exactly one result beat
// (combo_event_o, short_press_1_o, short_press_2_o, stable_levels_o), taken
// at an edge with out_valid_o high and out_stall_i low.
// A poll lands in the input register at its accept edge, and its result is
// written to the output register at the edge where the poll advances.
// Throughput is one poll per cycle while the receiver does not stall; all state
// updates for a poll happen between those two registers, so consecutive polls
// see each other's effects without bubbles.
// When the receiver stalls, the result is held and the poll behind it waits in
// the input register; in_stall_o rises only once both registers are full.
// Reset clears both valid flags, loads the default settings (50, 3000, 3000)
// and puts both buttons in the released state with all timers at zero.
// Configuration writes on the cfg_* channel are always ready and must only be
// issued while no poll is in flight.
// Depends on tbdc_pkg, tbdc_cfg_regs, tbdc_button and tbdc_combo.
module two_button_debounce_long_press_combo (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Poll channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                btn1_level_i,
  input  logic                btn2_level_i,
  input  tbdc_pkg::time_t     now_ms_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                combo_event_o,
  output logic                short_press_1_o,
  output logic                short_press_2_o,
  output logic [1:0]          stable_levels_o,
  // Configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  tbdc_pkg::cfg_val_t  cfg_data_i
);
  import tbdc_pkg::*;

  // Input register: the accepted poll waiting to be processed.
  logic  in_valid_q;
  logic  btn1_q, btn2_q;
  time_t now_q;

  // Output register: the finished result beat.
  logic       out_valid_q;
  logic       combo_q, short1_q, short2_q;
  logic [1:0] stable_q;

  logic        advance, take_in, both_low;
  logic        combo_ev, short1, short2, stable1, stable2;
  cfg_t        cfg;
  btn_step_t   step1, step2;
  combo_step_t step_c;

  // A poll is processed when the output register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;
  assign both_low   = !btn1_q && !btn2_q;

  tbdc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The per-button logic is skipped entirely on a combo poll.
  assign step1  = '{en: advance && !both_low, raw: btn1_q, now: now_q};
  assign step2  = '{en: advance && !both_low, raw: btn2_q, now: now_q};
  assign step_c = '{en: advance, both_low: both_low, now: now_q};

  tbdc_button u_btn1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step1),
    .cfg_i    (cfg),
    .short_o  (short1),
    .stable_o (stable1)
  );

  tbdc_button u_btn2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step2),
    .cfg_i    (cfg),
    .short_o  (short2),
    .stable_o (stable2)
  );

  tbdc_combo u_combo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_c),
    .cfg_i   (cfg),
    .event_o (combo_ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in || advance) begin
        in_valid_q <= take_in;
      end
      if (advance || !out_stall_i) begin
        out_valid_q <= advance;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      btn1_q <= btn1_level_i;
      btn2_q <= btn2_level_i;
      now_q  <= now_ms_i;
    end
    if (advance) begin
      combo_q  <= combo_ev;
      short1_q <= short1;
      short2_q <= short2;
      stable_q <= {stable2, stable1};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign combo_event_o   = combo_q;
  assign short_press_1_o = short1_q;
  assign short_press_2_o = short2_q;
  assign stable_levels_o = stable_q;

endmodule

FILE: rtl/tbdc_checker.sv
// Port-level checks for the two-button debouncer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tbdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       combo_event_o,
  input logic       short_press_1_o,
  input logic       short_press_2_o,
  input logic [1:0] stable_levels_o
);

  // A stalled result beat holds.
  `TBDC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(stable_levels_o) && $stable(combo_event_o), "result changed under stall")

  // The input side only backs up when the output side is full and stalled.
  `TBDC_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
    "input stalled without a stalled result")

  // A combo poll never reports a short press.
  `TBDC_ASSERT_IMPL(a_combo_excl, out_valid_o && combo_event_o,
    !short_press_1_o && !short_press_2_o, "combo and short press together")

  // A short press is reported on release, so the debounced level is high.
  `TBDC_ASSERT_IMPL(a_short_rel, out_valid_o && (short_press_1_o || short_press_2_o),
    (!short_press_1_o || stable_levels_o[0]) && (!short_press_2_o || stable_levels_o[1]),
    "short press while still pressed")

endmodule

bind two_button_debounce_long_press_combo tbdc_checker u_tbdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .combo_event_o   (combo_event_o),
  .short_press_1_o (short_press_1_o),
  .short_press_2_o (short_press_2_o),
  .stable_levels_o (stable_levels_o)
);

FILE: sim/two_button_debounce_long_press_combo_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-button debouncer with short-press and combo detection.
// Depends on tbdc_pkg and two_button_debounce_long_press_combo; it reads no files.

module two_button_debounce_long_press_combo_tb;
  import tbdc_pkg::*;

  // A poll is registered at its accept edge and its result when it advances to the output register.
  localparam int LATENCY = 2;
  // The longest legitimate quiet stretch is the receiver hold-off of HOLD_OFF_CYCLES.
  // Random gaps on either side are far shorter, so this limit only trips on a hang.
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int WATCHDOG_LIMIT  = 2000;
  // The fourth register index maps to nothing, and a write to it must be dropped.
  localparam logic [IdxBits-1:0] CfgNoReg = 2'd3;

  typedef struct packed {
    logic       combo_event;
    logic       short_press_1;
    logic       short_press_2;
    logic [1:0] stable_levels;
  } poll_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                btn1_level_i    = 1'b1;
  logic                btn2_level_i    = 1'b1;
  time_t               now_ms_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                combo_event_o;
  logic                short_press_1_o;
  logic                short_press_2_o;
  logic [1:0]          stable_levels_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [IdxBits-1:0]  cfg_index_i     = '0;
  cfg_val_t            cfg_data_i      = '0;

  two_button_debounce_long_press_combo dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .btn1_level_i    (btn1_level_i),
    .btn2_level_i    (btn2_level_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .combo_event_o   (combo_event_o),
    .short_press_1_o (short_press_1_o),
    .short_press_2_o (short_press_2_o),
    .stable_levels_o (stable_levels_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Behavioural copy of the debouncer. It starts in the post-reset state, since
  // reset is applied exactly once, and it is advanced once per accepted poll.
  // ---------------------------------------------------------------------------
  cfg_val_t   debounce_set   = DebounceRst;
  cfg_val_t   long_press_set = LongPressRst;
  cfg_val_t   combo_hold_set = ComboHoldRst;

  logic       combo_on       = 1'b0;
  logic       combo_done     = 1'b0;
  time_t      combo_t0       = '0;
  logic [1:0] last_raw       = 2'b11;
  logic [1:0] debounced      = 2'b11;
  logic [1:0] held_long      = 2'b00;
  time_t      changed_at [2] = '{default: '0};
  time_t      pressed_at [2] = '{default: '0};

  // Results owed by the block, oldest first.
  poll_result_t results_due[$];

  // One button on a poll that is not a combo. Returns 1 when a stable release
  // ends a press that never reached the long-press time.
  function automatic logic settle_button(input int b, input logic raw, input time_t stamp);
    logic  short_release;
    time_t since;
    short_release = 1'b0;
    if (raw != last_raw[b]) changed_at[b] = stamp;
    // Differences wrap modulo 2^32 simply by staying at the timestamp width.
    since = stamp - changed_at[b];
    if (since > time_t'(debounce_set) && raw != debounced[b]) begin
      debounced[b] = raw;
      if (!raw) begin
        pressed_at[b] = stamp;
        held_long[b]  = 1'b0;
      end else if (!held_long[b]) begin
        short_release = 1'b1;
      end
    end
    since = stamp - pressed_at[b];
    if (!debounced[b] && !held_long[b] && since >= time_t'(long_press_set)) held_long[b] = 1'b1;
    last_raw[b] = raw;
    return short_release;
  endfunction

  function automatic poll_result_t predict_poll(input logic l1, input logic l2,
                                                input time_t stamp);
    poll_result_t r;
    time_t        held;
    r = '0;
    if (!l1 && !l2) begin
      // Both pressed: only the combo timer runs, the buttons keep their history.
      if (!combo_on) begin
        combo_on   = 1'b1;
        combo_t0   = stamp;
        combo_done = 1'b0;
      end
      held = stamp - combo_t0;
      if (!combo_done && held >= time_t'(combo_hold_set)) begin
        combo_done    = 1'b1;
        r.combo_event = 1'b1;
      end
    end else begin
      combo_on        = 1'b0;
      combo_t0        = '0;
      combo_done      = 1'b0;
      r.short_press_1 = settle_button(0, l1, stamp);
      r.short_press_2 = settle_button(1, l2, stamp);
    end
    r.stable_levels = {debounced[1], debounced[0]};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: checks every result beat against the oldest prediction and
  // drives out_stall_i, either at random or for a requested hold-off.
  // ---------------------------------------------------------------------------
  int   mismatches   = 0;
  int   stall_pct    = 0;
  int   hold_len     = 0;
  logic hold_trigger = 1'b0;
  logic hold_seen    = 1'b0;
  int   hold_left    = 0;

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    poll_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result beat arrived with no poll outstanding");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("combo_event", {1'b0, want.combo_event}, {1'b0, combo_event_o});
          check_field("short_press_1", {1'b0, want.short_press_1}, {1'b0, short_press_1_o});
          check_field("short_press_2", {1'b0, want.short_press_2}, {1'b0, short_press_2_o});
          check_field("stable_levels", want.stable_levels, stable_levels_o);
        end
      end
      // A toggle of hold_trigger asks for one long stall, counted here.
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Poll side.
  // ---------------------------------------------------------------------------
  int    send_idle_pct = 0;
  int    polls_sent    = 0;
  time_t cursor        = '0;

  // Offers one poll beat and returns at the edge where it is taken. The
  // prediction is made there, so it sees the settings in force at that moment.
  task automatic send_poll(input logic l1, input logic l2, input time_t stamp);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    btn1_level_i <= l1;
    btn2_level_i <= l2;
    now_ms_i     <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    results_due.push_back(predict_poll(l1, l2, stamp));
    polls_sent++;
  endtask

  // Stops offering polls and waits until every owed result has been taken,
  // then lets the pipeline settle.
  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Register beats keep cfg_valid_i high back to back; the caller lowers it.
  task automatic write_reg(input logic [IdxBits-1:0] idx, input cfg_val_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgDebounce:  debounce_set   = val;
      CfgLongPress: long_press_set = val;
      CfgComboHold: combo_hold_set = val;
      default: ;
    endcase
  endtask

  // Reprograms all three timers while the block is idle. The unmapped index is
  // written too, with random data, to show that it leaves the timers alone.
  task automatic set_registers(input cfg_val_t deb, input cfg_val_t lng, input cfg_val_t cmb);
    wait_all_results();
    write_reg(CfgNoReg, cfg_val_t'($urandom()));
    write_reg(CfgDebounce, deb);
    write_reg(CfgLongPress, lng);
    write_reg(CfgComboHold, cmb);
    cfg_valid_i <= 1'b0;
  endtask

  // Holds the raw levels for dur ms after bounces polls of random contact bounce.
  // Steps scale with the duration so that a hold takes a handful of polls.
  task automatic hold_levels(input logic l1, input logic l2, input int unsigned dur,
                             input int unsigned bounces);
    int unsigned spent;
    int unsigned max_step;
    repeat (bounces) begin
      cursor += $urandom_range(0, int'(debounce_set) / 2);
      send_poll(l1 ^ 1'($urandom_range(1)), l2 ^ 1'($urandom_range(1)), cursor);
    end
    max_step = dur / 5 + 1;
    spent    = 0;
    send_poll(l1, l2, cursor);
    while (spent < dur) begin
      int unsigned step;
      step    = $urandom_range(1, max_step);
      cursor += step;
      spent  += step;
      send_poll(l1, l2, cursor);
    end
  endtask

  // One gesture: mostly a press or release held for a duration picked around
  // the current thresholds, sometimes raw noise with jumps in time.
  task automatic random_gesture();
    logic [1:0]  lv;
    int unsigned dur;
    int unsigned deb;
    int unsigned lng;
    int unsigned cmb;
    deb = 32'(debounce_set);
    lng = 32'(long_press_set);
    cmb = 32'(combo_hold_set);
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) == 0) cursor = $urandom();
        else cursor += $urandom_range(0, 3);
        send_poll(1'($urandom_range(1)), 1'($urandom_range(1)), cursor);
      end
    end else begin
      // Releases of both buttons are favoured so that presses get to end.
      lv = ($urandom_range(2) == 0) ? 2'b11 : 2'($urandom_range(3));
      case ($urandom_range(3))
        0:       dur = $urandom_range(0, deb);
        1:       dur = deb + 1 + $urandom_range(0, lng);
        2:       dur = deb + lng + $urandom_range(0, cmb + lng);
        default: dur = cmb + $urandom_range(0, 2);
      endcase
      hold_levels(lv[1], lv[0], dur, ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3));
    end
    // Now and then the sender waits for the block to drain completely.
    if ($urandom_range(49) == 0) wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset levels, then a press of button one that only settles once the raw
  // level has been steady strictly longer than the debounce time, and a short
  // release that raises its short-press flag.
  task automatic test_single_press();
    send_poll(1'b1, 1'b1, 32'd0);
    send_poll(1'b0, 1'b1, 32'd100);
    send_poll(1'b0, 1'b1, 32'd150);
    send_poll(1'b0, 1'b1, 32'd151);
    send_poll(1'b1, 1'b1, 32'd200);
    send_poll(1'b1, 1'b1, 32'd251);
  endtask

  // Both buttons down: the combo fires once at exactly the hold time, not again
  // while held, and the per-button history survives the combo untouched.
  task automatic test_combo_hold();
    send_poll(1'b0, 1'b0, 32'd1000);
    send_poll(1'b0, 1'b0, 32'd3999);
    send_poll(1'b0, 1'b0, 32'd4000);
    send_poll(1'b0, 1'b0, 32'd9000);
    send_poll(1'b1, 1'b1, 32'd9001);
  endtask

  // A press and a release of button two whose timing spans the timestamp wrap.
  task automatic test_timestamp_wrap();
    send_poll(1'b1, 1'b0, 32'hFFFF_FFF0);
    send_poll(1'b1, 1'b0, 32'h0000_0030);
    send_poll(1'b1, 1'b1, 32'h0000_0040);
    send_poll(1'b1, 1'b1, 32'h0000_0080);
  endtask

  // All timers at zero, then all at their maximum.
  task automatic test_register_extremes();
    set_registers('0, '0, '0);
    // A zero long-press time marks every press long at once: no short press.
    send_poll(1'b0, 1'b1, 32'h0000_1000);
    send_poll(1'b0, 1'b1, 32'h0000_1001);
    send_poll(1'b1, 1'b1, 32'h0000_1003);
    send_poll(1'b0, 1'b0, 32'h0000_1004);
    set_registers('1, '1, '1);
    send_poll(1'b1, 1'b0, 32'h0000_2000);
    send_poll(1'b1, 1'b0, 32'h0001_1FFF);
    send_poll(1'b1, 1'b0, 32'h0001_2000);
    send_poll(1'b0, 1'b0, 32'h0002_0000);
    send_poll(1'b0, 1'b0, 32'h0002_FFFF);
  endtask

  // Random gestures under one idling pattern on each side.
  task automatic test_random_gestures(input int n, input int idle_pct, input int stall_p);
    int first;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    first         = polls_sent;
    cursor        = $urandom();
    while (polls_sent - first < n) random_gesture();
  endtask

  // The receiver stalls for a long stretch while polls keep coming, so both
  // registers fill and the block has to push back on its input.
  task automatic test_receiver_hold_off();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len     <= HOLD_OFF_CYCLES;
    hold_trigger <= ~hold_trigger;
    repeat (3) begin
      hold_levels(1'b0, 1'b1, int'(debounce_set) + 1 + $urandom_range(0, 20), 1);
      hold_levels(1'b1, 1'b1, int'(debounce_set) + 1, 0);
    end
    wait_all_results();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_press();
    test_combo_hold();
    test_timestamp_wrap();
    test_register_extremes();

    // Tight thresholds reach every branch within a few polls per gesture.
    set_registers(16'd5, 16'd60, 16'd40);
    test_random_gestures(300, 0, 0);
    set_registers(DebounceRst, LongPressRst, ComboHoldRst);
    test_random_gestures(300, 59, 0);
    set_registers(16'd0, 16'hFFFF, 16'd1);
    test_random_gestures(300, 0, 59);
    test_receiver_hold_off();
    set_registers(cfg_val_t'($urandom_range(0, 40)), cfg_val_t'($urandom_range(0, 200)),
                  cfg_val_t'($urandom_range(0, 200)));
    test_random_gestures(300, 18, 18);

    wait_all_results();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (results_due.size() != 0) $error("%0d results never arrived", results_due.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tbdc_pkg.sv
rtl/tbdc_cfg_regs.sv
rtl/tbdc_button.sv
rtl/tbdc_combo.sv
rtl/two_button_debounce_long_press_combo.sv
rtl/tbdc_checker.sv
sim/two_button_debounce_long_press_combo_tb.sv
